@@ rtl/core/fbr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framebuffer blitter package
// Shared types, codes and defaults for the raster-op framebuffer engine.
// ----------------------------------------------------------------------------
package fbr_pkg;

    // Default screen geometry
    localparam int SCREEN_WIDTH_DEF  = 128;
    localparam int SCREEN_HEIGHT_DEF = 64;

    // Command codes; code 7 is not a command
    typedef enum logic [2:0] {
        CMD_CLEAR      = 3'd0,
        CMD_SET        = 3'd1,
        CMD_FILL       = 3'd2,
        CMD_FLUSH      = 3'd3,
        CMD_BLIT_BEGIN = 3'd4,
        CMD_BLIT_DATA  = 3'd5,
        CMD_READ       = 3'd6
    } t_cmd;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FILL,
        ST_RMW,
        ST_RDWAIT,
        ST_DONE
    } t_state;

    // Result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NO_BLIT = 2'd1;
    localparam logic [1:0] STATUS_BAD_CMD = 2'd2;

    // Raster op codes
    localparam logic [7:0] ROP_ASSIGN = 8'd0;
    localparam logic [7:0] ROP_AND    = 8'd1;
    localparam logic [7:0] ROP_OR     = 8'd2;
    localparam logic [7:0] ROP_XOR    = 8'd3;
    localparam logic [7:0] ROP_XNOR   = 8'd4;

    // Finished result handed from the sequencer to the output register
    typedef struct packed {
        logic        load;
        logic [1:0]  status;
        logic [7:0]  pixel;
        logic [15:0] src_offset;
        logic        blit_active;
    } t_result;

endpackage

@@ rtl/core/fbr_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framebuffer pixel store
// Single-port pixel memory with registered read data.
// ----------------------------------------------------------------------------
module fbr_store #(
    parameter int ADDR_WIDTH = 13
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [ADDR_WIDTH-1:0] i_addr,
    input  logic [7:0]            i_wdata,
    output logic [7:0]            o_rdata
);

    localparam int DEPTH = 1 << ADDR_WIDTH;

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    // Write on strobe, read the addressed pixel every cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/fbr_rop.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raster op unit
// Combines a source pixel with the current target pixel.
// ----------------------------------------------------------------------------
module fbr_rop (
    input  logic [7:0] i_op,
    input  logic [7:0] i_cur,
    input  logic [7:0] i_src,
    output logic [7:0] o_pix
);

    // Unknown ops keep the target pixel
    always_comb begin
        case (i_op)
            fbr_pkg::ROP_ASSIGN: o_pix = i_src;
            fbr_pkg::ROP_AND:    o_pix = i_cur & i_src;
            fbr_pkg::ROP_OR:     o_pix = i_cur | i_src;
            fbr_pkg::ROP_XOR:    o_pix = i_cur ^ i_src;
            fbr_pkg::ROP_XNOR:   o_pix = ~(i_cur ^ i_src);
            default:             o_pix = i_cur;
        endcase
    end

endmodule

@@ rtl/core/fbr_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framebuffer command sequencer
// Runs one command at a time: rectangle walker for clear and fill, single
// pixel access, and read-modify-write through the raster op unit for blits.
// ----------------------------------------------------------------------------
module fbr_ctrl #(
    parameter  int SCREEN_WIDTH  = fbr_pkg::SCREEN_WIDTH_DEF,
    parameter  int SCREEN_HEIGHT = fbr_pkg::SCREEN_HEIGHT_DEF,
    localparam int XB = (SCREEN_WIDTH  > 1) ? $clog2(SCREEN_WIDTH)  : 1,
    localparam int YB = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1,
    localparam int AW = XB + YB
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // command beats
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [2:0]       i_command,
    input  logic [7:0]       i_x_pos,
    input  logic [7:0]       i_y_pos,
    input  logic [7:0]       i_rect_width,
    input  logic [7:0]       i_rect_height,
    input  logic [7:0]       i_data_value,
    // result hand-off
    input  logic             i_out_free,
    output fbr_pkg::t_result o_result,
    // pixel store
    output logic             o_mem_we,
    output logic [AW-1:0]    o_mem_addr,
    output logic [7:0]       o_mem_wdata,
    input  logic [7:0]       i_mem_rdata
);

    localparam logic [8:0] W9 = 9'(SCREEN_WIDTH);
    localparam logic [8:0] H9 = 9'(SCREEN_HEIGHT);

    fbr_pkg::t_state r_state, n_state;

    logic        r_init, n_init;
    logic [2:0]  r_cmd, n_cmd;
    logic [7:0]  r_px, n_px, r_py, n_py, r_rw, n_rw, r_rh, n_rh, r_data, n_data;
    logic [7:0]  r_wx, n_wx, r_wy, n_wy, r_wy0, n_wy0;
    logic [8:0]  r_wxlim, n_wxlim, r_wylim, n_wylim;
    logic [7:0]  r_bx, n_bx, r_by, n_by, r_bw, n_bw, r_bh, n_bh;
    logic [7:0]  r_bcol, n_bcol, r_brow, n_brow, r_bop, n_bop;
    logic        r_busy, n_busy;
    logic [15:0] r_offset, n_offset;
    logic [1:0]  r_status, n_status;
    logic [7:0]  r_pix, n_pix;

    logic          accept;
    logic [AW-1:0] fill_addr, blit_addr, pix_addr;
    logic [8:0]    tx, ty, wx_inc, wy_inc, xend, yend, xlim, ylim;
    logic          blit_on, pix_on, fill_empty;
    logic [7:0]    row_inc, col_inc;
    logic [7:0]    adv_row, adv_col;
    logic          adv_busy;
    logic [7:0]    rop_pix;

    assign accept     = i_in_valid && (r_state == fbr_pkg::ST_IDLE);
    assign o_in_stall = (r_state != fbr_pkg::ST_IDLE);

    // Walker position and address
    assign fill_addr = {r_wy[YB-1:0], r_wx[XB-1:0]};
    assign wx_inc    = {1'b0, r_wx} + 9'd1;
    assign wy_inc    = {1'b0, r_wy} + 9'd1;

    // Clip the fill rectangle at the screen edge
    assign xend       = {1'b0, r_px} + {1'b0, r_rw};
    assign yend       = {1'b0, r_py} + {1'b0, r_rh};
    assign xlim       = (xend < W9) ? xend : W9;
    assign ylim       = (yend < H9) ? yend : H9;
    assign fill_empty = ({1'b0, r_px} >= xlim) || ({1'b0, r_py} >= ylim);

    // Single pixel address for set and read
    assign pix_on   = ({1'b0, r_px} < W9) && ({1'b0, r_py} < H9);
    assign pix_addr = {r_py[YB-1:0], r_px[XB-1:0]};

    // Blit target address
    assign tx        = {1'b0, r_bx} + {1'b0, r_bcol};
    assign ty        = {1'b0, r_by} + {1'b0, r_brow};
    assign blit_on   = (tx < W9) && (ty < H9);
    assign blit_addr = {ty[YB-1:0], tx[XB-1:0]};

    // Column-major blit advance: rows inside a column, then next column
    assign row_inc = r_brow + 8'd1;
    assign col_inc = r_bcol + 8'd1;
    always_comb begin
        adv_row  = row_inc;
        adv_col  = r_bcol;
        adv_busy = r_busy;
        if (row_inc >= r_bh) begin
            adv_row = 8'd0;
            adv_col = col_inc;
            if (col_inc >= r_bw) begin
                adv_busy = 1'b0;
            end
        end
    end

    fbr_rop u_rop (
        .i_op  (r_bop),
        .i_cur (i_mem_rdata),
        .i_src (r_data),
        .o_pix (rop_pix)
    );

    // Next state and datapath
    always_comb begin
        n_state  = r_state;
        n_init   = r_init;
        n_cmd    = r_cmd;
        n_px     = r_px;
        n_py     = r_py;
        n_rw     = r_rw;
        n_rh     = r_rh;
        n_data   = r_data;
        n_wx     = r_wx;
        n_wy     = r_wy;
        n_wy0    = r_wy0;
        n_wxlim  = r_wxlim;
        n_wylim  = r_wylim;
        n_bx     = r_bx;
        n_by     = r_by;
        n_bw     = r_bw;
        n_bh     = r_bh;
        n_bcol   = r_bcol;
        n_brow   = r_brow;
        n_bop    = r_bop;
        n_busy   = r_busy;
        n_offset = r_offset;
        n_status = r_status;
        n_pix    = r_pix;

        o_mem_we    = 1'b0;
        o_mem_addr  = pix_addr;
        o_mem_wdata = r_data;

        o_result.load        = 1'b0;
        o_result.status      = r_status;
        o_result.pixel       = r_pix;
        o_result.src_offset  = r_offset;
        o_result.blit_active = r_busy;

        case (r_state)
            fbr_pkg::ST_IDLE: begin
                if (accept) begin
                    n_cmd    = i_command;
                    n_px     = i_x_pos;
                    n_py     = i_y_pos;
                    n_rw     = i_rect_width;
                    n_rh     = i_rect_height;
                    n_data   = i_data_value;
                    n_status = fbr_pkg::STATUS_OK;
                    n_pix    = 8'd0;
                    n_state  = fbr_pkg::ST_EXEC;
                end
            end

            fbr_pkg::ST_EXEC: begin
                n_state = fbr_pkg::ST_DONE;
                case (fbr_pkg::t_cmd'(r_cmd))
                    fbr_pkg::CMD_CLEAR: begin
                        n_wx    = 8'd0;
                        n_wy    = 8'd0;
                        n_wy0   = 8'd0;
                        n_wxlim = W9;
                        n_wylim = H9;
                        n_state = fbr_pkg::ST_FILL;
                    end
                    fbr_pkg::CMD_SET: begin
                        o_mem_we = pix_on;
                    end
                    fbr_pkg::CMD_FILL: begin
                        n_wx    = r_px;
                        n_wy    = r_py;
                        n_wy0   = r_py;
                        n_wxlim = xlim;
                        n_wylim = ylim;
                        if (!fill_empty) begin
                            n_state = fbr_pkg::ST_FILL;
                        end
                    end
                    fbr_pkg::CMD_FLUSH: begin
                        n_state = fbr_pkg::ST_DONE;
                    end
                    fbr_pkg::CMD_BLIT_BEGIN: begin
                        n_bx     = r_px;
                        n_by     = r_py;
                        n_bw     = r_rw;
                        n_bh     = r_rh;
                        n_bop    = r_data;
                        n_bcol   = 8'd0;
                        n_brow   = 8'd0;
                        n_offset = 16'd0;
                        n_busy   = (r_rw != 8'd0) && (r_rh != 8'd0);
                    end
                    fbr_pkg::CMD_BLIT_DATA: begin
                        if (!r_busy) begin
                            n_status = fbr_pkg::STATUS_NO_BLIT;
                        end else if (blit_on) begin
                            // fetch the target pixel, combine next cycle
                            o_mem_addr = blit_addr;
                            n_state    = fbr_pkg::ST_RMW;
                        end else begin
                            // off-screen target: drop the write, still advance
                            n_offset = r_offset + 16'd1;
                            n_brow   = adv_row;
                            n_bcol   = adv_col;
                            n_busy   = adv_busy;
                        end
                    end
                    fbr_pkg::CMD_READ: begin
                        if (pix_on) begin
                            n_state = fbr_pkg::ST_RDWAIT;
                        end
                    end
                    default: begin
                        n_status = fbr_pkg::STATUS_BAD_CMD;
                    end
                endcase
            end

            fbr_pkg::ST_FILL: begin
                o_mem_we   = 1'b1;
                o_mem_addr = fill_addr;
                if (wy_inc == r_wylim) begin
                    n_wy = r_wy0;
                    n_wx = wx_inc[7:0];
                    if (wx_inc == r_wxlim) begin
                        n_init  = 1'b0;
                        n_state = r_init ? fbr_pkg::ST_IDLE : fbr_pkg::ST_DONE;
                    end
                end else begin
                    n_wy = wy_inc[7:0];
                end
            end

            fbr_pkg::ST_RMW: begin
                o_mem_we    = 1'b1;
                o_mem_addr  = blit_addr;
                o_mem_wdata = rop_pix;
                n_offset    = r_offset + 16'd1;
                n_brow      = adv_row;
                n_bcol      = adv_col;
                n_busy      = adv_busy;
                n_state     = fbr_pkg::ST_DONE;
            end

            fbr_pkg::ST_RDWAIT: begin
                n_pix   = i_mem_rdata;
                n_state = fbr_pkg::ST_DONE;
            end

            fbr_pkg::ST_DONE: begin
                if (i_out_free) begin
                    o_result.load = 1'b1;
                    n_state       = fbr_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = fbr_pkg::ST_IDLE;
            end
        endcase
    end

    // State register; reset starts the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fbr_pkg::ST_FILL;
        end else begin
            r_state <= n_state;
        end
    end

    // Walker, blit and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init   <= 1'b1;
            r_cmd    <= 3'd0;
            r_px     <= 8'd0;
            r_py     <= 8'd0;
            r_rw     <= 8'd0;
            r_rh     <= 8'd0;
            r_data   <= 8'd0;
            r_wx     <= 8'd0;
            r_wy     <= 8'd0;
            r_wy0    <= 8'd0;
            r_wxlim  <= W9;
            r_wylim  <= H9;
            r_bx     <= 8'd0;
            r_by     <= 8'd0;
            r_bw     <= 8'd0;
            r_bh     <= 8'd0;
            r_bcol   <= 8'd0;
            r_brow   <= 8'd0;
            r_bop    <= 8'd0;
            r_busy   <= 1'b0;
            r_offset <= 16'd0;
            r_status <= fbr_pkg::STATUS_OK;
            r_pix    <= 8'd0;
        end else begin
            r_init   <= n_init;
            r_cmd    <= n_cmd;
            r_px     <= n_px;
            r_py     <= n_py;
            r_rw     <= n_rw;
            r_rh     <= n_rh;
            r_data   <= n_data;
            r_wx     <= n_wx;
            r_wy     <= n_wy;
            r_wy0    <= n_wy0;
            r_wxlim  <= n_wxlim;
            r_wylim  <= n_wylim;
            r_bx     <= n_bx;
            r_by     <= n_by;
            r_bw     <= n_bw;
            r_bh     <= n_bh;
            r_bcol   <= n_bcol;
            r_brow   <= n_brow;
            r_bop    <= n_bop;
            r_busy   <= n_busy;
            r_offset <= n_offset;
            r_status <= n_status;
            r_pix    <= n_pix;
        end
    end

endmodule

@@ rtl/core/framebuffer_blitter_rop_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framebuffer blitter with raster ops
// Command-driven pixel engine over an on-chip frame store, one result beat
// per command beat.
// ----------------------------------------------------------------------------
// After reset the block sweeps the frame store to zero, one pixel a cycle;
// command beats are stalled meanwhile, source_base writes are taken at any
// time. Commands then run one at a time on a single-port store: flush, set
// pixel, blit begin, unknown command, blit data without a blit, and read
// pixel or blit data aimed at an off-screen pixel go from the execute state
// straight to the done state; read pixel and blit data on an on-screen pixel
// pass through a further state for the registered read of the store. Fill
// walks the clipped pixels, and clear the whole screen, with the walker
// writing one pixel a cycle. A finished result sits in an output register,
// so the next command is taken while the previous result waits; a further
// finished result holds the sequencer until that register has been taken.
// ----------------------------------------------------------------------------
module framebuffer_blitter_rop_unit #(
    parameter int SCREEN_WIDTH  = fbr_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = fbr_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_source_base,
    // command channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_command,
    input  logic [7:0]  i_x_pos,
    input  logic [7:0]  i_y_pos,
    input  logic [7:0]  i_rect_width,
    input  logic [7:0]  i_rect_height,
    input  logic [7:0]  i_data_value,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [7:0]  o_pixel_out,
    output logic [15:0] o_next_source_address,
    output logic        o_blit_active
);

    localparam int XB = (SCREEN_WIDTH  > 1) ? $clog2(SCREEN_WIDTH)  : 1;
    localparam int YB = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
    localparam int AW = XB + YB;

    logic [15:0]      r_source_base;
    logic             r_out_valid;
    logic [1:0]       r_status;
    logic [7:0]       r_pixel;
    logic [15:0]      r_next_addr;
    logic             r_blit_active;

    fbr_pkg::t_result result;
    logic             out_free;
    logic             mem_we;
    logic [AW-1:0]    mem_addr;
    logic [7:0]       mem_wdata;
    logic [7:0]       mem_rdata;

    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;

    fbr_store #(
        .ADDR_WIDTH (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    fbr_ctrl #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_x_pos       (i_x_pos),
        .i_y_pos       (i_y_pos),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .i_data_value  (i_data_value),
        .i_out_free    (out_free),
        .o_result      (result),
        .o_mem_we      (mem_we),
        .o_mem_addr    (mem_addr),
        .o_mem_wdata   (mem_wdata),
        .i_mem_rdata   (mem_rdata)
    );

    // Source base register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_base <= 16'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_source_base <= i_cfg_source_base;
        end
    end

    // Result beat register: load a finished result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (result.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (result.load) begin
            r_status      <= result.status;
            r_pixel       <= result.pixel;
            r_next_addr   <= r_source_base + result.src_offset;
            r_blit_active <= result.blit_active;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_status              = r_status;
    assign o_pixel_out           = r_pixel;
    assign o_next_source_address = r_next_addr;
    assign o_blit_active         = r_blit_active;

endmodule

@@ rtl/core/fbr_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framebuffer blitter port checker
// Watches the top-level ports for sequencing and result consistency.
// ----------------------------------------------------------------------------
module fbr_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [15:0] i_cfg_source_base,
    input  logic        i_in_valid,
    input  logic        o_in_stall,
    input  logic [2:0]  i_command,
    input  logic [7:0]  i_x_pos,
    input  logic [7:0]  i_y_pos,
    input  logic [7:0]  i_rect_width,
    input  logic [7:0]  i_rect_height,
    input  logic [7:0]  i_data_value,
    input  logic        o_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  o_status,
    input  logic [7:0]  o_pixel_out,
    input  logic [15:0] o_next_source_address,
    input  logic        o_blit_active
);

    // One command at a time: an accepted beat stalls the channel next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("command channel not stalled after accept");

    // Only a successful command can carry a read pixel
    a_pixel_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != fbr_pkg::STATUS_OK)) |-> (o_pixel_out == 8'd0))
        else $error("pixel reported with error status");

    // Blit data without a blit cannot leave a blit running
    a_no_blit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == fbr_pkg::STATUS_NO_BLIT)) |-> !o_blit_active)
        else $error("blit active on a no-blit result");

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_status) && $stable(o_pixel_out)
             && $stable(o_next_source_address) && $stable(o_blit_active)))
        else $error("stalled result beat changed");

endmodule

bind framebuffer_blitter_rop_unit fbr_checker u_fbr_checker (.*);
